/* design/sthit_pkg.sv */
// shared types and codes for the shape table hit test block
`default_nettype none

package sthit_pkg;

    // table depth default
    localparam int MAX_SHAPES_DEF = 16;

    // draw depth after reset
    localparam logic [9:0] DRAW_DEPTH_RESET = 10'd100;

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // shape kinds
    localparam logic [1:0] KIND_POINT   = 2'd0;
    localparam logic [1:0] KIND_SEGMENT = 2'd1;
    localparam logic [1:0] KIND_RECT    = 2'd2;
    localparam logic [1:0] KIND_CIRCLE  = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    // one stored shape: a sorted box (x0,y0)-(x1,y1), or center and radius in x1
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic [9:0]         depth;
    } entry_t;

endpackage

`default_nettype wire

/* design/shape_table_point_hit_test.sv */
// shape table with point hit test: storage, add, clear and query scan
`default_nettype none

// Shape table with point hit test. Items arrive on the s_ stream (command and
// kind in tuser, coordinates and depth in tdata); every item returns exactly one
// result on the m_ stream. Shapes live in one synchronous memory of MAX_SHAPES
// entries with one read port. Points, segments and rectangles are stored as
// sorted boxes (rectangle bounds already truncated toward zero), circles as
// center and radius. An add, a clear or an unused command goes from acceptance
// through the wait state to the output register. A query reads one stored
// shape per cycle from the memory port and feeds a three-stage test pipeline
// (read, squares and box compare, sum and compare), then its result takes the
// same path through the wait state. One item is in work at a time; the next
// one is accepted while the result still waits in the output register, and
// its own result holds the input off until that register is free. draw_depth
// is written on the cfg channel, which is always ready.
module shape_table_point_hit_test
    import sthit_pkg::*;
#(
    parameter int MAX_SHAPES = MAX_SHAPES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write: draw_depth in cfg_data[9:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] first_x, [31:16] first_y, [47:32] second_x, [63:48] second_y,
    // [73:64] shape_depth, [79:74] zero
    input  wire logic [79:0] s_tdata,
    // [1:0] command, [3:2] shape_kind
    input  wire logic [3:0]  s_tuser,
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] hit, [2:1] status, [7:3] zero
    output logic [7:0]       m_tdata
);

    localparam int CW = $clog2(MAX_SHAPES + 1);
    localparam int AW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    // input field views
    logic [1:0]         in_cmd;
    logic [1:0]         in_kind;
    logic signed [15:0] in_ax;
    logic signed [15:0] in_ay;
    logic signed [15:0] in_bx;
    logic signed [15:0] in_by;
    logic [9:0]         in_depth;

    assign in_cmd   = s_tuser[1:0];
    assign in_kind  = s_tuser[3:2];
    assign in_ax    = s_tdata[15:0];
    assign in_ay    = s_tdata[31:16];
    assign in_bx    = s_tdata[47:32];
    assign in_by    = s_tdata[63:48];
    assign in_depth = s_tdata[73:64];

    // control registers
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          s1_valid_reg, s1_valid_next;
    logic          s2_valid_reg, s2_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic [9:0]    draw_depth_reg;

    // payload registers
    logic signed [15:0] qx_reg, qx_next;
    logic signed [15:0] qy_reg, qy_next;
    logic               acc_reg, acc_next;
    logic               res_hit_reg, res_hit_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               out_hit_reg, out_hit_next;
    logic [1:0]         out_status_reg, out_status_next;

    // test pipeline stage two
    logic        s2_circle_reg;
    logic        s2_depth_ok_reg;
    logic        s2_box_reg;
    logic [33:0] s2_dx2_reg;
    logic [33:0] s2_dy2_reg;
    logic [31:0] s2_r2_reg;

    // shape memory
    entry_t          mem [MAX_SHAPES];
    entry_t          rd_data;
    entry_t          wr_data;
    logic            wr_en;
    logic            rd_en;

    logic in_fire;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // truncate a Q12.4 value toward zero to a whole unit
    function automatic logic signed [15:0] trunc_whole(input logic signed [15:0] v);
        logic [15:0] adj;
        adj = v[15] ? (v + 16'sd15) : v;
        return {adj[15:4], 4'b0000};
    endfunction

    // shape check and the entry written by an add
    logic               bad_shape;
    logic signed [15:0] min_x, max_x, min_y, max_y;

    always_comb
    begin
        min_x = (in_ax < in_bx) ? in_ax : in_bx;
        max_x = (in_ax < in_bx) ? in_bx : in_ax;
        min_y = (in_ay < in_by) ? in_ay : in_by;
        max_y = (in_ay < in_by) ? in_by : in_ay;

        case (in_kind)
            KIND_SEGMENT: bad_shape = ((in_ax != in_bx) && (in_ay != in_by))
                                      || ((in_ax == in_bx) && (in_ay == in_by));
            KIND_RECT:    bad_shape = (in_ax == in_bx) || (in_ay == in_by);
            KIND_CIRCLE:  bad_shape = (in_bx <= 16'sd0);
            default:      bad_shape = 1'b0;
        endcase

        wr_data.kind  = in_kind;
        wr_data.depth = in_depth;
        case (in_kind)
            KIND_POINT:
            begin
                wr_data.x0 = in_ax;
                wr_data.y0 = in_ay;
                wr_data.x1 = in_ax;
                wr_data.y1 = in_ay;
            end
            KIND_RECT:
            begin
                wr_data.x0 = trunc_whole(min_x);
                wr_data.y0 = trunc_whole(min_y);
                wr_data.x1 = trunc_whole(max_x);
                wr_data.y1 = trunc_whole(max_y);
            end
            KIND_CIRCLE:
            begin
                wr_data.x0 = in_ax;
                wr_data.y0 = in_ay;
                wr_data.x1 = in_bx;
                wr_data.y1 = in_by;
            end
            default:
            begin
                wr_data.x0 = min_x;
                wr_data.y0 = min_y;
                wr_data.x1 = max_x;
                wr_data.y1 = max_y;
            end
        endcase
    end

    assign wr_en = in_fire && (in_cmd == CMD_ADD) && !bad_shape
                   && (count_reg != CW'(MAX_SHAPES));
    assign rd_en = (state_reg == ST_SCAN) && (scan_reg < count_reg);

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[scan_reg[AW-1:0]];
        end
    end

    // stage two: depth check, box test and squares
    logic signed [16:0] dx, dy;
    assign dx = {qx_reg[15], qx_reg} - {rd_data.x0[15], rd_data.x0};
    assign dy = {qy_reg[15], qy_reg} - {rd_data.y0[15], rd_data.y0};

    always_ff @(posedge clk)
    begin
        s2_circle_reg   <= (rd_data.kind == KIND_CIRCLE);
        s2_depth_ok_reg <= (rd_data.depth <= draw_depth_reg);
        s2_box_reg      <= (qx_reg >= rd_data.x0) && (qx_reg <= rd_data.x1)
                           && (qy_reg >= rd_data.y0) && (qy_reg <= rd_data.y1);
        s2_dx2_reg      <= 34'(dx * dx);
        s2_dy2_reg      <= 34'(dy * dy);
        s2_r2_reg       <= 32'(rd_data.x1 * rd_data.x1);
    end

    // stage three: per-shape hit
    logic s2_hit;
    assign s2_hit = s2_depth_ok_reg
                    && (s2_circle_reg
                        ? ({1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg} <= {3'b000, s2_r2_reg})
                        : s2_box_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        s1_valid_next   = 1'b0;
        s2_valid_next   = s1_valid_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        acc_next        = acc_reg;
        res_hit_next    = res_hit_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_hit_next    = out_hit_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_hit_next    = 1'b0;
                    res_status_next = STATUS_OK;
                    state_next      = ST_WAIT;
                    case (in_cmd)
                        CMD_ADD:
                        begin
                            if (bad_shape)
                            begin
                                res_status_next = STATUS_INVALID;
                            end
                            else if (count_reg == CW'(MAX_SHAPES))
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            qx_next    = in_ax;
                            qy_next    = in_ay;
                            acc_next   = 1'b0;
                            scan_next  = '0;
                            state_next = ST_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    scan_next     = scan_reg + 1'b1;
                    s1_valid_next = 1'b1;
                end
                if (s2_valid_reg && s2_hit)
                begin
                    acc_next = 1'b1;
                end
                if (!rd_en && !s1_valid_reg && !s2_valid_reg)
                begin
                    res_hit_next    = acc_reg;
                    res_status_next = STATUS_OK;
                    state_next      = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = res_hit_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            scan_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            draw_depth_reg <= DRAW_DEPTH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                draw_depth_reg <= cfg_data[9:0];
            end
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        acc_reg        <= acc_next;
        res_hit_reg    <= res_hit_next;
        res_status_reg <= res_status_next;
        out_hit_reg    <= out_hit_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_status_reg, out_hit_reg};

endmodule

`default_nettype wire

/* design/sthit_check.sv */
// port checker for the shape table hit test block, bound to the top level
`default_nettype none

module sthit_check
    import sthit_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction dropped while stalled");

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // a hit only comes with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[2:1] == STATUS_OK))
        else $error("hit reported with a reject status");

    // status is a known code and padding is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[2:1] == STATUS_OK) || (m_tdata[2:1] == STATUS_INVALID)
                      || (m_tdata[2:1] == STATUS_FULL)) && (m_tdata[7:3] == 5'd0))
        else $error("bad status code or nonzero padding");

endmodule

bind shape_table_point_hit_test sthit_check u_sthit_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* bench/shape_table_checker.sv */
// result predictor and checker for the shape table hit test block
module shape_table_checker
    import sthit_pkg::*;
#(
    parameter int MAX_SHAPES = MAX_SHAPES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          error_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
    } hit_answer_t;

    // mirror of the shape table
    logic [1:0]    kind_tab  [MAX_SHAPES];
    int            ax_tab    [MAX_SHAPES];
    int            ay_tab    [MAX_SHAPES];
    int            bx_tab    [MAX_SHAPES];
    int            by_tab    [MAX_SHAPES];
    logic [9:0]    depth_tab [MAX_SHAPES];
    int            stored_shapes;
    logic [9:0]    draw_limit;
    hit_answer_t   expected_answers [$];

    function automatic int as_coord(logic [15:0] raw);
        logic signed [15:0] value;
        value = raw;
        return value;
    endfunction

    // does stored shape idx contain the point (px, py)
    function automatic bit shape_contains(int idx, int px, int py);
        int     ax, ay, bx, by;
        int     x_lo, x_hi, y_lo, y_hi;
        longint dx, dy, radius;
        ax = ax_tab[idx];
        ay = ay_tab[idx];
        bx = bx_tab[idx];
        by = by_tab[idx];
        x_lo = (ax < bx) ? ax : bx;
        x_hi = (ax > bx) ? ax : bx;
        y_lo = (ay < by) ? ay : by;
        y_hi = (ay > by) ? ay : by;
        case (kind_tab[idx])
            KIND_POINT:
                return px == ax && py == ay;
            KIND_SEGMENT:
            begin
                // row match is tried before column match
                if (py == ay)
                    return px >= x_lo && px <= x_hi;
                if (px == ax)
                    return py >= y_lo && py <= y_hi;
                return 1'b0;
            end
            KIND_RECT:
                // bounds truncated toward zero to whole units
                return px >= (x_lo / 16) * 16 && px <= (x_hi / 16) * 16 &&
                       py >= (y_lo / 16) * 16 && py <= (y_hi / 16) * 16;
            default:
            begin
                dx = px - ax;
                dy = py - ay;
                radius = bx;
                return dx * dx + dy * dy <= radius * radius;
            end
        endcase
    endfunction

    // update the mirrored table for one item and return its answer
    function automatic hit_answer_t apply_item(logic [1:0] cmd, logic [1:0] kind,
                                               int ax, int ay, int bx, int by,
                                               logic [9:0] depth);
        hit_answer_t answer;
        bit          rejected;
        answer.hit = 1'b0;
        answer.status = STATUS_OK;
        rejected = 1'b0;
        case (cmd)
            CMD_ADD:
            begin
                case (kind)
                    KIND_SEGMENT: rejected = (ax != bx && ay != by) || (ax == bx && ay == by);
                    KIND_RECT:    rejected = (ax == bx) || (ay == by);
                    KIND_CIRCLE:  rejected = (bx <= 0);
                    default:      rejected = 1'b0;
                endcase
                if (rejected)
                    answer.status = STATUS_INVALID;
                else if (stored_shapes >= MAX_SHAPES)
                    answer.status = STATUS_FULL;
                else
                begin
                    kind_tab[stored_shapes] = kind;
                    ax_tab[stored_shapes] = ax;
                    ay_tab[stored_shapes] = ay;
                    bx_tab[stored_shapes] = bx;
                    by_tab[stored_shapes] = by;
                    depth_tab[stored_shapes] = depth;
                    stored_shapes++;
                end
            end
            CMD_QUERY:
            begin
                for (int i = 0; i < stored_shapes; i++)
                begin
                    if (depth_tab[i] <= draw_limit && shape_contains(i, ax, ay))
                        answer.hit = 1'b1;
                end
            end
            CMD_CLEAR:
                stored_shapes = 0;
            default:
                ;
        endcase
        return answer;
    endfunction

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        hit_answer_t want;
        if (!rst_n)
        begin
            stored_shapes = 0;
            draw_limit = DRAW_DEPTH_RESET;
            expected_answers.delete();
            pending_results = 0;
        end
        else
        begin
            // register write transaction
            if (cfg_valid && cfg_ready)
                draw_limit = cfg_data[9:0];

            // result transaction against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("unexpected result: hit %0d status %0d", m_tdata[0], m_tdata[2:1]);
                    error_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (m_tdata[0] !== want.hit)
                    begin
                        $error("hit mismatch: expected %0d, actual %0d", want.hit, m_tdata[0]);
                        error_count++;
                    end
                    if (m_tdata[2:1] !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_tdata[2:1]);
                        error_count++;
                    end
                end
            end

            // input transaction
            if (s_tvalid && s_tready)
                expected_answers.push_back(apply_item(s_tuser[1:0], s_tuser[3:2],
                                                      as_coord(s_tdata[15:0]),
                                                      as_coord(s_tdata[31:16]),
                                                      as_coord(s_tdata[47:32]),
                                                      as_coord(s_tdata[63:48]),
                                                      s_tdata[73:64]));
            pending_results = expected_answers.size();
        end
    end

endmodule

/* bench/tb.sv */
// top of the shape table hit test bench: clock, reset, stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sthit_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         ITEM_TARGET  = 1700;
    localparam int         PHASES       = 5;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = 30;

    typedef struct {
        logic [1:0] kind;
        int         ax;
        int         ay;
        int         bx;
        int         by;
    } aim_shape_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [15:0] first_x, [31:16] first_y, [47:32] second_x, [63:48] second_y,
    // [73:64] shape_depth, [79:74] zero
    logic [79:0] s_tdata = '0;
    // [1:0] command, [3:2] shape_kind
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] hit, [2:1] status, [7:3] zero
    logic [7:0]  m_tdata;

    int          error_count;
    int          pending_results;
    int          items_sent = 0;
    int          hold_requests = 0;
    bit          steady_flow = 1'b0;
    logic [9:0]  depth_setting = DRAW_DEPTH_RESET;
    aim_shape_t  sent_shapes [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    shape_table_point_hit_test #(.MAX_SHAPES(MAX_SHAPES_DEF)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    shape_table_checker #(.MAX_SHAPES(MAX_SHAPES_DEF)) table_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .error_count    (error_count),
        .pending_results(pending_results)
    );

    function automatic int pick_between(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int any_coord();
        return pick_between(-32768, 32767);
    endfunction

    // wrap to the signed 16-bit range the block sees
    function automatic int fit16(int value);
        logic signed [15:0] low_half;
        low_half = value[15:0];
        return low_half;
    endfunction

    function automatic int step_off(int span);
        int mag;
        mag = pick_between(1, span);
        return ($urandom_range(0, 1) == 0) ? mag : -mag;
    endfunction

    // mostly short idle stretches, a few long ones
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return pick_between(1, 3);
        return pick_between(8, 40);
    endfunction

    // depths lean toward what the current draw depth lets through
    function automatic logic [9:0] pick_depth();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 10'($urandom_range(0, depth_setting));
        if (r < 7)
            return depth_setting;
        return 10'($urandom_range(0, 1023));
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_item(input logic [1:0] cmd, input logic [1:0] kind,
                             input int ax, input int ay, input int bx, input int by,
                             input logic [9:0] depth);
        int gap;
        gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {kind, cmd};
        s_tdata  <= {6'd0, depth, by[15:0], bx[15:0], ay[15:0], ax[15:0]};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // query with random filler in the fields a query ignores
    task automatic send_query(input int px, input int py);
        send_item(CMD_QUERY, 2'($urandom_range(0, 3)), fit16(px), fit16(py),
                  any_coord(), any_coord(), 10'($urandom_range(0, 1023)));
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), any_coord(),
                  any_coord(), any_coord(), any_coord(), 10'($urandom_range(0, 1023)));
    endtask

    // wait until every result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic write_draw_depth(input logic [9:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= {6'd0, value};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        depth_setting = value;
    endtask

    // add a shape, mostly well formed, small or spanning the full range
    task automatic add_random_shape();
        aim_shape_t shape;
        int         span;
        bit         wide;
        bit         broken;
        wide = ($urandom_range(0, 9) == 0);
        broken = ($urandom_range(0, 9) == 0);
        span = wide ? 32767 : 200;
        shape.kind = 2'($urandom_range(0, 3));
        shape.ax = wide ? any_coord() : pick_between(-1500, 1500);
        shape.ay = wide ? any_coord() : pick_between(-1500, 1500);
        shape.bx = any_coord();
        shape.by = any_coord();
        case (shape.kind)
            KIND_SEGMENT:
            begin
                shape.bx = shape.ax;
                shape.by = shape.ay;
                if (broken)
                begin
                    // diagonal, otherwise left at zero length
                    if ($urandom_range(0, 1) == 0)
                    begin
                        shape.bx = fit16(shape.ax + step_off(span));
                        shape.by = fit16(shape.ay + step_off(span));
                    end
                end
                else if ($urandom_range(0, 1) == 0)
                    shape.bx = fit16(shape.ax + step_off(span));
                else
                    shape.by = fit16(shape.ay + step_off(span));
            end
            KIND_RECT:
            begin
                shape.bx = fit16(shape.ax + step_off(span));
                shape.by = fit16(shape.ay + step_off(span));
                if (broken)
                begin
                    if ($urandom_range(0, 1) == 0)
                        shape.bx = shape.ax;
                    else
                        shape.by = shape.ay;
                end
            end
            KIND_CIRCLE:
            begin
                if (!broken)
                    shape.bx = pick_between(1, wide ? 32767 : 300);
                else if ($urandom_range(0, 1) == 0)
                    shape.bx = 0;
                else
                    shape.bx = pick_between(-32768, -1);
            end
            default:
                ;
        endcase
        send_item(CMD_ADD, shape.kind, shape.ax, shape.ay, shape.bx, shape.by, pick_depth());
        if (!broken || shape.kind == KIND_POINT)
            sent_shapes.push_back(shape);
    endtask

    // query close to or on the edge of a shape sent earlier
    task automatic query_near(input aim_shape_t s);
        int px, py, r;
        case (s.kind)
            KIND_POINT:
            begin
                px = s.ax;
                py = s.ay;
                if ($urandom_range(0, 3) == 0)
                    px = px + pick_between(-1, 1);
                if ($urandom_range(0, 3) == 0)
                    py = py + pick_between(-1, 1);
            end
            KIND_SEGMENT:
            begin
                if (s.ay == s.by)
                begin
                    py = s.ay;
                    px = pick_between(((s.ax < s.bx) ? s.ax : s.bx) - 3,
                                      ((s.ax > s.bx) ? s.ax : s.bx) + 3);
                end
                else
                begin
                    px = s.ax;
                    py = pick_between(((s.ay < s.by) ? s.ay : s.by) - 3,
                                      ((s.ay > s.by) ? s.ay : s.by) + 3);
                end
                // step off the line now and then
                if ($urandom_range(0, 4) == 0)
                begin
                    px = px + pick_between(-1, 1);
                    py = py + pick_between(-1, 1);
                end
            end
            KIND_RECT:
            begin
                px = pick_between(((s.ax < s.bx) ? s.ax : s.bx) - 20,
                                  ((s.ax > s.bx) ? s.ax : s.bx) + 20);
                py = pick_between(((s.ay < s.by) ? s.ay : s.by) - 20,
                                  ((s.ay > s.by) ? s.ay : s.by) + 20);
            end
            default:
            begin
                r = s.bx;
                px = pick_between(s.ax - r - 4, s.ax + r + 4);
                py = pick_between(s.ay - r - 4, s.ay + r + 4);
            end
        endcase
        send_query(px, py);
    endtask

    // clear, fill, probe, with some stray items at the end
    task automatic run_sequence();
        steady_flow = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) != 0)
        begin
            send_item(CMD_CLEAR, 2'($urandom_range(0, 3)), any_coord(), any_coord(),
                      any_coord(), any_coord(), 10'($urandom_range(0, 1023)));
            sent_shapes.delete();
        end
        repeat ($urandom_range(0, 20)) add_random_shape();
        repeat ($urandom_range(2, 12))
        begin
            if (sent_shapes.size() > 0 && $urandom_range(0, 9) < 8)
                query_near(sent_shapes[$urandom_range(0, sent_shapes.size() - 1)]);
            else
                send_query(any_coord(), any_coord());
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) send_noise();
    endtask

    // extremes, every command and each rejection rule
    task automatic run_directed();
        send_query(0, 0);
        send_item(CMD_UNUSED, KIND_CIRCLE, 32767, -32768, 32767, -32768, 10'd1023);
        send_item(CMD_ADD, KIND_POINT, -32768, 32767, 0, 0, 10'd0);
        send_query(-32768, 32767);
        // too deep for the reset draw depth
        send_item(CMD_ADD, KIND_SEGMENT, -32768, 5, 32767, 5, 10'd1023);
        send_query(0, 5);
        send_item(CMD_ADD, KIND_SEGMENT, 16, -32768, 16, 32767, DRAW_DEPTH_RESET);
        send_query(16, 1000);
        // diagonal and zero-length segments
        send_item(CMD_ADD, KIND_SEGMENT, 0, 0, 16, 16, 10'd1);
        send_item(CMD_ADD, KIND_SEGMENT, 3, 3, 3, 3, 10'd1);
        // rectangles with a shared x or y
        send_item(CMD_ADD, KIND_RECT, 5, 0, 5, 40, 10'd1);
        send_item(CMD_ADD, KIND_RECT, 0, 7, 40, 7, 10'd1);
        // unsorted corners, bounds truncate to -32..32
        send_item(CMD_ADD, KIND_RECT, 40, -40, -40, 40, 10'd99);
        send_query(-33, 0);
        send_query(-32, 32);
        // zero and most negative radius
        send_item(CMD_ADD, KIND_CIRCLE, 0, 0, 0, 0, 10'd1);
        send_item(CMD_ADD, KIND_CIRCLE, 0, 0, -32768, 0, 10'd1);
        send_item(CMD_ADD, KIND_CIRCLE, 32767, -32768, 32767, 0, 10'd50);
        send_query(0, -32768);
        send_query(-1, -32768);
        send_item(CMD_CLEAR, KIND_POINT, 0, 0, 0, 0, 10'd0);
        send_query(16, 0);
    endtask

    // receiver side: random stalls plus requested long hold-offs
    initial
    begin : result_pacing
        int stall_left;
        int hold_left;
        int holds_served;
        stall_left = 0;
        hold_left = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (steady_flow)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left = idle_length() - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // run limit
    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // main stimulus
    initial
    begin : stimulus
        logic [9:0] depth_plan [PHASES];
        int         phase_end;
        depth_plan[0] = DRAW_DEPTH_RESET;
        depth_plan[1] = 10'd1023;
        depth_plan[2] = 10'd0;
        depth_plan[3] = 10'($urandom_range(1, 1022));
        depth_plan[4] = 10'd512;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                write_draw_depth(depth_plan[p]);
            end
            // make the block back up against a stalled receiver
            if (p == 1 || p == 3)
                hold_requests++;
            phase_end = ITEM_TARGET * (p + 1) / PHASES;
            while (items_sent < phase_end)
                run_sequence();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
